>>> rtl/core/lcg48_pkg.sv
// Shared types and constants for the 48-bit LCG random generator.
package lcg48_pkg;

    localparam int STATE_W = 48;
    localparam int VALUE_W = 63;
    localparam int BOUND_W = 31;
    localparam int HALF_W  = 24;

    localparam logic [STATE_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_ADD  = 48'h0000_0000_000B;

    // request kinds
    localparam logic [1:0] KIND_RAW     = 2'd0;
    localparam logic [1:0] KIND_BOUNDED = 2'd1;
    localparam logic [1:0] KIND_LONG    = 2'd2;
    localparam logic [1:0] KIND_DOUBLE  = 2'd3;

    // result register update codes
    localparam logic [3:0] RES_NONE = 4'd0;
    localparam logic [3:0] RES_RAW  = 4'd1;
    localparam logic [3:0] RES_HI31 = 4'd2;
    localparam logic [3:0] RES_LO31 = 4'd3;
    localparam logic [3:0] RES_HI26 = 4'd4;
    localparam logic [3:0] RES_LO27 = 4'd5;
    localparam logic [3:0] RES_POW2 = 4'd6;
    localparam logic [3:0] RES_MOD  = 4'd7;
    localparam logic [3:0] RES_BAD  = 4'd8;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       div_load;
        logic       div_en;
        logic [3:0] res_op;
        logic       out_load;
    } lcg48_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       bound_zero;
        logic       bound_pow2;
        logic       reject;
    } lcg48_status_t;

endpackage

>>> rtl/core/lcg48_ctrl.sv
// Request sequencer for the LCG generator: draws, divide loop, result handoff.
module lcg48_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  lcg48_pkg::lcg48_status_t status,
    output lcg48_pkg::lcg48_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_MUL      = 3'd2;
    localparam logic [2:0] ST_USE      = 3'd3;
    localparam logic [2:0] ST_DIV      = 3'd4;
    localparam logic [2:0] ST_CHECK    = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    localparam logic [4:0] MUL_LAST = 5'd3;
    localparam logic [4:0] DIV_LAST = 5'(lcg48_pkg::BOUND_W - 1);

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cnt_next = '0;
                if (status.kind == lcg48_pkg::KIND_BOUNDED && status.bound_zero)
                begin
                    cmd.res_op = lcg48_pkg::RES_BAD;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = cnt_reg[1:0];
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_USE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_USE:
            begin
                case (status.kind)
                    lcg48_pkg::KIND_RAW:
                    begin
                        cmd.res_op = lcg48_pkg::RES_RAW;
                        state_next = ST_FINISH;
                    end
                    lcg48_pkg::KIND_BOUNDED:
                    begin
                        if (status.bound_pow2)
                        begin
                            cmd.res_op = lcg48_pkg::RES_POW2;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.div_load = 1'b1;
                            state_next   = ST_DIV;
                        end
                    end
                    lcg48_pkg::KIND_LONG:
                    begin
                        if (!phase_reg)
                        begin
                            cmd.res_op = lcg48_pkg::RES_HI31;
                            phase_next = 1'b1;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            cmd.res_op = lcg48_pkg::RES_LO31;
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        if (!phase_reg)
                        begin
                            cmd.res_op = lcg48_pkg::RES_HI26;
                            phase_next = 1'b1;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            cmd.res_op = lcg48_pkg::RES_LO27;
                            state_next = ST_FINISH;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_CHECK:
            begin
                // rejected draw: go around for a fresh one
                if (status.reject)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.res_op = lcg48_pkg::RES_MOD;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/lcg48_dp.sv
// Datapath: LCG state, shared 24x24 multiplier, restoring divider, result registers.
module lcg48_dp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [47:0]              cfg_wdata,
    input  logic [1:0]               kind,
    input  logic [5:0]               bit_count,
    input  logic [30:0]              bound,
    input  lcg48_pkg::lcg48_cmd_t    cmd,
    output lcg48_pkg::lcg48_status_t status,
    output logic [62:0]              value,
    output logic                     bad_bound
);

    localparam int HW = lcg48_pkg::HALF_W;
    localparam logic [HW-1:0] M_LO = lcg48_pkg::LCG_MULT[HW-1:0];
    localparam logic [HW-1:0] M_HI = lcg48_pkg::LCG_MULT[2*HW-1:HW];

    logic [47:0] st_reg, st_next;
    logic [47:0] prod_reg, prod_next;
    logic [47:0] acc_reg, acc_next;
    logic [1:0]  kind_reg;
    logic [5:0]  nbits_reg;
    logic [30:0] bound_reg;
    logic [30:0] r_reg, r_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] dq_reg, dq_next;
    logic [62:0] res_reg, res_next;
    logic        bad_reg, bad_next;
    logic [62:0] value_reg;
    logic        bad_out_reg;

    logic [HW-1:0] op_a, op_b;
    logic [47:0]   prod_add;
    logic [31:0]   trial;
    logic [32:0]   chk_sum;
    logic [5:0]    nsat;
    logic [5:0]    raw_sh;
    logic [31:0]   raw_val;
    logic [61:0]   pow2_prod;
    logic [30:0]   draw31;

    // multiply operand select: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
    always_comb
    begin
        case (cmd.mul_step)
            2'd0:
            begin
                op_a = st_reg[HW-1:0];
                op_b = M_LO;
            end
            2'd1:
            begin
                op_a = st_reg[HW-1:0];
                op_b = M_HI;
            end
            2'd2:
            begin
                op_a = st_reg[2*HW-1:HW];
                op_b = M_LO;
            end
            default:
            begin
                op_a = st_reg[HW-1:0];
                op_b = M_LO;
            end
        endcase
    end

    // step 1 adds the low product as is, later steps add cross terms shifted up
    assign prod_add = (cmd.mul_step == 2'd1) ? prod_reg : {prod_reg[HW-1:0], {HW{1'b0}}};

    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        st_next   = st_reg;
        if (cfg_we)
        begin
            st_next = cfg_wdata ^ lcg48_pkg::LCG_MULT;
        end
        else if (cmd.mul_en)
        begin
            prod_next = op_a * op_b;
            if (cmd.mul_step == 2'd0)
                acc_next = lcg48_pkg::LCG_ADD;
            else
                acc_next = acc_reg + prod_add;
            if (cmd.mul_step == 2'd3)
                st_next = acc_reg + prod_add;
        end
    end

    assign draw31 = st_reg[47:17];

    // restoring divide, one quotient bit per cycle; only the remainder is kept
    assign trial = {rem_reg, dq_reg[30]};

    always_comb
    begin
        r_next   = r_reg;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        if (cmd.div_load)
        begin
            r_next   = draw31;
            rem_next = '0;
            dq_next  = draw31;
        end
        else if (cmd.div_en)
        begin
            dq_next = {dq_reg[29:0], 1'b0};
            if (trial >= {1'b0, bound_reg})
                rem_next = 31'(trial - {1'b0, bound_reg});
            else
                rem_next = trial[30:0];
        end
    end

    // r - v + bound - 1 reaching 2^31 means the draw is rejected
    assign chk_sum = {2'b00, r_reg} - {2'b00, rem_reg} + {2'b00, bound_reg} - 33'd1;

    assign nsat    = (nbits_reg > 6'd32) ? 6'd32 : nbits_reg;
    assign raw_sh  = 6'd32 - nsat;
    assign raw_val = st_reg[47:16] >> raw_sh;

    assign pow2_prod = {31'd0, draw31} * {31'd0, bound_reg};

    always_comb
    begin
        res_next = res_reg;
        bad_next = bad_reg;
        case (cmd.res_op)
            lcg48_pkg::RES_NONE:
            begin
                res_next = res_reg;
            end
            lcg48_pkg::RES_RAW:
            begin
                res_next = {31'd0, raw_val};
                bad_next = 1'b0;
            end
            lcg48_pkg::RES_HI31:
            begin
                res_next = {draw31, 32'd0};
                bad_next = 1'b0;
            end
            lcg48_pkg::RES_LO31:
            begin
                res_next = {res_reg[62:32], 1'b0, draw31};
            end
            lcg48_pkg::RES_HI26:
            begin
                res_next = {10'd0, st_reg[47:22], 27'd0};
                bad_next = 1'b0;
            end
            lcg48_pkg::RES_LO27:
            begin
                res_next = {res_reg[62:27], st_reg[47:21]};
            end
            lcg48_pkg::RES_POW2:
            begin
                res_next = {32'd0, pow2_prod[61:31]};
                bad_next = 1'b0;
            end
            lcg48_pkg::RES_MOD:
            begin
                res_next = {32'd0, rem_reg};
                bad_next = 1'b0;
            end
            lcg48_pkg::RES_BAD:
            begin
                res_next = '0;
                bad_next = 1'b1;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= lcg48_pkg::LCG_MULT;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        res_reg  <= res_next;
        bad_reg  <= bad_next;
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            nbits_reg <= bit_count;
            bound_reg <= bound;
        end
        if (cmd.out_load)
        begin
            value_reg   <= res_reg;
            bad_out_reg <= bad_reg;
        end
    end

    assign status.kind       = kind_reg;
    assign status.bound_zero = (bound_reg == '0);
    assign status.bound_pow2 = ((bound_reg & (bound_reg - 31'd1)) == '0);
    assign status.reject     = chk_sum[31];

    assign value     = value_reg;
    assign bad_bound = bad_out_reg;

endmodule

>>> rtl/core/lcg48_random_generator.sv
// Top level of the 48-bit LCG random generator.
// Requests arrive on in_valid/in_ready with kind, bit_count and bound; one
// result per request leaves on out_valid/out_ready as value and bad_bound.
// cfg_we/cfg_wdata load a seed; the state becomes seed XOR 0x5DEECE66D.
// The user must write seeds only while no request is in flight; the block itself does not enforce it.
// Each draw advances the state through a shared 24x24 multiplier. A raw
// draw or a power-of-two bound takes one draw, long and double fraction two,
// a zero bound none; other bounded ints repeat, per draw tried, the
// multiply, the handoff state, the restoring divide and the rejection
// check, until a draw is accepted.
// One request is in work at a time; in_ready is high only when idle, so the
// next request is taken no earlier than the cycle after a result is loaded.
// A finished result sits in the output register while the next request is
// accepted; if the receiver stalls, the following result waits in the
// sequencer until the output register frees up.
// Reset loads the state with the scrambled zero seed and empties the output.
module lcg48_random_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [47:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [5:0]  bit_count,
    input  logic [30:0] bound,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [62:0] value,
    output logic        bad_bound
);

    lcg48_pkg::lcg48_cmd_t    cmd;
    lcg48_pkg::lcg48_status_t status;

    lcg48_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcg48_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .kind      (kind),
        .bit_count (bit_count),
        .bound     (bound),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .bad_bound (bad_bound)
    );

endmodule

>>> rtl/core/lcg48_checker.sv
// Port-level checks for the LCG random generator, bound to the top level.
module lcg48_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  kind,
    input logic [5:0]  bit_count,
    input logic [30:0] bound,
    input logic        out_valid,
    input logic        out_ready,
    input logic [62:0] value,
    input logic        bad_bound
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(bad_bound))
        else $error("result changed while stalled");

    // waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable({kind, bit_count, bound}))
        else $error("request changed while waiting");

    // error results carry a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_bound |-> value == 63'd0)
        else $error("bad bound result with nonzero value");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // a new result is only presented after the request finished its work
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in work");

endmodule

bind lcg48_random_generator lcg48_checker u_lcg48_checker (.*);

>>> tb/tb_lcg48_random_generator.sv
// Self-checking testbench for the 48-bit LCG random generator.
module tb_lcg48_random_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASE_DRAWS = 240;
    localparam int          N_DIRECTED  = 23;
    localparam int          N_SEEDS     = 6;

    typedef struct packed {
        logic [62:0] value;
        logic        bad_bound;
    } draw_result_t;

    typedef struct packed {
        logic [1:0]  req_kind;
        logic [5:0]  nbits;
        logic [30:0] limit;
        logic        typed;
        logic [62:0] want_value;
        logic        want_bad;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [47:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [5:0]  bit_count;
    logic [30:0] bound;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [62:0] value;
    logic        bad_bound;

    logic [47:0]  lcg_state;
    draw_result_t expected_draws[$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    int unsigned  rejected_draws = 0;
    int unsigned  zero_bounds = 0;
    int unsigned  seeds_loaded = 0;
    int unsigned  kind_count [4] = '{0, 0, 0, 0};
    int unsigned  cycle_count = 0;
    int unsigned  stall_left = 0;
    bit           burst_mode = 1'b0;

    // the first row is the well-known first 32-bit draw of a zero seed
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{lcg48_pkg::KIND_RAW,     6'd32, 31'd0,         1'b1, 63'h0_BB20_B460, 1'b0},
        '{lcg48_pkg::KIND_RAW,     6'd1,  31'h7FFF_FFFF, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_RAW,     6'd0,  31'h7FFF_FFFF, 1'b1, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_RAW,     6'd63, 31'd0,         1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_RAW,     6'd33, 31'h5555_5555, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_RAW,     6'd31, 31'd0,         1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'd0,         1'b1, 63'd0, 1'b1},
        '{lcg48_pkg::KIND_BOUNDED, 6'd63, 31'd0,         1'b1, 63'd0, 1'b1},
        '{lcg48_pkg::KIND_BOUNDED, 6'd5,  31'd1,         1'b1, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'h4000_0000, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'd2,         1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'd3,         1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'd10,        1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'h7FFF_FFFF, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'h4000_0001, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'h4000_0001, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'h4000_0001, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_BOUNDED, 6'd0,  31'h5555_5555, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_LONG,    6'd0,  31'd0,         1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_LONG,    6'd63, 31'h7FFF_FFFF, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_DOUBLE,  6'd0,  31'd0,         1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_DOUBLE,  6'd32, 31'h2AAA_AAAA, 1'b0, 63'd0, 1'b0},
        '{lcg48_pkg::KIND_RAW,     6'd32, 31'd0,         1'b0, 63'd0, 1'b0}
    };

    lcg48_random_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .bit_count (bit_count),
        .bound     (bound),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .bad_bound (bad_bound)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_draws.size());
            $display("** lcg48_random_generator: FAILED **");
            $finish;
        end
    end

    // advance the generator and take the top bits (width saturates at 32)
    function automatic logic [31:0] advance_lcg(input int unsigned width);
        int unsigned n;
        n = (width > 32) ? 32 : width;
        lcg_state = lcg_state * lcg48_pkg::LCG_MULT + lcg48_pkg::LCG_ADD;
        if (n == 0)
            return '0;
        return 32'(lcg_state >> (lcg48_pkg::STATE_W - n));
    endfunction

    function automatic logic [62:0] bounded_draw(input logic [30:0] limit);
        logic [63:0] lim;
        logic [63:0] r;
        logic [63:0] v;
        lim = 64'(limit);
        if ((lim & (lim - 1)) == 0)
            return 63'((lim * 64'(advance_lcg(31))) >> 31);
        r = 64'(advance_lcg(31));
        v = r % lim;
        // redraw while the 31-bit window would overflow
        while (r - v + lim - 1 >= 64'h8000_0000)
        begin
            rejected_draws++;
            r = 64'(advance_lcg(31));
            v = r % lim;
        end
        return 63'(v);
    endfunction

    function automatic draw_result_t predict_draw(input logic [1:0] k, input logic [5:0] nbits,
                                                  input logic [30:0] limit);
        draw_result_t res;
        logic [62:0]  upper;
        res = '0;
        case (k)
            lcg48_pkg::KIND_RAW:
                res.value = 63'(advance_lcg(nbits));
            lcg48_pkg::KIND_BOUNDED:
                if (limit == '0)
                    res.bad_bound = 1'b1;
                else
                    res.value = bounded_draw(limit);
            lcg48_pkg::KIND_LONG:
            begin
                upper = 63'(advance_lcg(31));
                res.value = (upper << 32) + 63'(advance_lcg(31));
            end
            default:
            begin
                upper = 63'(advance_lcg(26));
                res.value = (upper << 27) + 63'(advance_lcg(27));
            end
        endcase
        return res;
    endfunction

    // result side: random stall before each result, then check against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        draw_result_t want;
        int unsigned  stall;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            results_seen++;
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %h bad_bound %b",
                         $time, value, bad_bound);
                mismatches++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (value !== want.value)
                begin
                    $display("%0t: value mismatch, expected %h, got %h",
                             $time, want.value, value);
                    mismatches++;
                end
                if (bad_bound !== want.bad_bound)
                begin
                    $display("%0t: bad_bound mismatch, expected %b, got %b",
                             $time, want.bad_bound, bad_bound);
                    mismatches++;
                end
            end
            stall = burst_mode ? 0 : $urandom_range(0, 17);
            stall_left <= stall;
            out_ready  <= (stall == 0);
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end
    end

    // called at the edge that took the previous request, so valid is never dropped and raised
    // in the same step
    task automatic issue_request(input logic [1:0] k, input logic [5:0] nbits,
                                 input logic [30:0] limit, input logic typed,
                                 input draw_result_t typed_res);
        int unsigned  gap;
        draw_result_t res;
        gap = burst_mode ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        bit_count <= nbits;
        bound     <= limit;
        do @(posedge clk); while (!in_ready);
        res = predict_draw(k, nbits, limit);
        expected_draws.push_back(typed ? typed_res : res);
        kind_count[k]++;
        if (k == lcg48_pkg::KIND_BOUNDED && limit == '0)
            zero_bounds++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_draws.size() != 0);
    endtask

    task automatic load_seed(input logic [47:0] seed);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lcg_state = seed ^ lcg48_pkg::LCG_MULT;
        seeds_loaded++;
    endtask

    task automatic random_request();
        logic [1:0]   k;
        logic [5:0]   nbits;
        logic [30:0]  limit;
        int unsigned  pick;
        draw_result_t unused;
        unused = '0;
        k = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        nbits = (pick < 7) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 9);
        case (pick)
            0:       limit = '0;
            1, 2:    limit = 31'(1) << $urandom_range(0, 30);
            3, 4:    limit = 31'($urandom_range(1, 100));
            5, 6:    limit = 31'($urandom_range(32'h4000_0001, 32'h7FFF_FFFF));
            default: limit = 31'($urandom);
        endcase
        if ($urandom_range(0, 39) == 0)
            burst_mode = !burst_mode;
        issue_request(k, nbits, limit, 1'b0, unused);
        if ($urandom_range(0, 99) == 0)
            wait_drained();
    endtask

    initial
    begin
        logic [47:0]  seeds [N_SEEDS];
        draw_result_t typed_res;
        in_valid  = 1'b0;
        kind      = '0;
        bit_count = '0;
        bound     = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        // all-zero, all-one, and the seed that leaves a zero state
        seeds[0] = 48'h0;
        seeds[1] = 48'hFFFF_FFFF_FFFF;
        seeds[2] = lcg48_pkg::LCG_MULT;
        seeds[3] = {16'($urandom), $urandom};
        seeds[4] = 48'd42;
        seeds[5] = {16'($urandom), $urandom};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        lcg_state = lcg48_pkg::LCG_MULT;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            typed_res.value     = directed_rows[i].want_value;
            typed_res.bad_bound = directed_rows[i].want_bad;
            issue_request(directed_rows[i].req_kind, directed_rows[i].nbits,
                          directed_rows[i].limit, directed_rows[i].typed, typed_res);
        end

        for (int s = 0; s < N_SEEDS; s++)
        begin
            load_seed(seeds[s]);
            for (int n = 0; n < PHASE_DRAWS; n++)
                random_request();
        end

        wait_drained();
        // catch any stray result after the last expected one
        repeat (60) @(posedge clk);

        $display("Checked %0d results over %0d seeds: raw %0d, bounded %0d, long %0d, double %0d",
                 results_seen, seeds_loaded, kind_count[lcg48_pkg::KIND_RAW],
                 kind_count[lcg48_pkg::KIND_BOUNDED], kind_count[lcg48_pkg::KIND_LONG],
                 kind_count[lcg48_pkg::KIND_DOUBLE]);
        $display("Bounded draws hit %0d rejected draws and %0d zero bounds; %0d mismatches",
                 rejected_draws, zero_bounds, mismatches);
        if (mismatches == 0)
            $display("** lcg48_random_generator: PASSED **");
        else
            $display("** lcg48_random_generator: FAILED **");
        $finish;
    end

endmodule

>>> lcg48_random_generator.f
rtl/core/lcg48_pkg.sv
rtl/core/lcg48_ctrl.sv
rtl/core/lcg48_dp.sv
rtl/core/lcg48_random_generator.sv
rtl/core/lcg48_checker.sv
tb/tb_lcg48_random_generator.sv
